// File: hdl/pal_pkg.sv
// package for the piecewise amplitude leveller: item and config types,
// segment tables, rounding helpers and the segment offset calculation
// no dependencies
package pal_pkg;

	// field widths
	localparam int SMP_W   = 24;
	localparam int THR_W   = 23;
	localparam int PASS_W  = 3;
	localparam int CNT_W   = 4;
	localparam int GAIN_W  = 15;
	localparam int MAG_W   = 24;
	localparam int PROD_W  = GAIN_W + MAG_W;
	localparam int FRAC_W  = 14;
	localparam int RND_W   = PROD_W - FRAC_W;
	localparam int OFFS_W  = 26;
	localparam int OFFS_XW = OFFS_W + 2;
	localparam int VAL_W   = 28;
	localparam int SEGMENTS = 6;
	localparam int SEG_W   = 3;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	// the segment whose breakpoint is the noise threshold
	localparam int NOISE_SEG = 1;

	// reset register values
	localparam logic [THR_W-1:0]  THR_RESET    = 23'd839;
	localparam logic [PASS_W-1:0] PASSES_RESET = 3'd2;

	// gains, Q1.14, segment 0 in the low slot
	localparam logic [SEGMENTS-1:0][GAIN_W-1:0] SEG_GAIN = {
		15'd13107, 15'd16384, 15'd19661, 15'd19661, 15'd16384, 15'd13107
	};

	// breakpoints, Q1.23; the noise slot is replaced by the register
	localparam logic [SEGMENTS-1:0][MAG_W-1:0] SEG_LIMIT = {
		24'd8388608, 24'd4194304, 24'd2516582, 24'd838861, 24'd0, 24'd839
	};

	// output magnitude when no breakpoint covers the sample, 0.99 in Q1.23
	localparam logic [MAG_W-1:0] CLIP_099 = 24'd8304722;

	// rounding constant for the Q1.14 gain products
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(8192);

	// saturation bounds of a 24 bit sample
	localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'(8388607);
	localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(-8388608);

	// register indexes on the config port
	typedef enum logic {
		REG_NOISE_THRESHOLD = 1'b0,
		REG_NUM_PASSES      = 1'b1
	} pal_reg_t;

	typedef logic signed [OFFS_W-1:0] offs_t;
	typedef offs_t [SEGMENTS-1:0] offs_arr_t;

	// config seen by every cell
	typedef struct packed {
		logic [THR_W-1:0] threshold;
		offs_arr_t        offsets;
	} pal_cfg_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_in;
		logic                    last_in;
	} pal_in_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    last_out;
	} pal_out_t;

	// item handed from cell to cell
	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    last;
	} pal_smp_t;

	// round half up of a gain product, elaboration time only
	function automatic longint rnd_gain(input longint g, input longint x);
		return (g * x + 64'sd8192) >>> 14;
	endfunction

	// fixed parts of the offset chain
	localparam longint K_ADJ0 = rnd_gain(longint'(SEG_GAIN[0]), longint'(SEG_LIMIT[0]));
	localparam longint K_OFF1 = K_ADJ0 - rnd_gain(longint'(SEG_GAIN[1]),
		longint'(SEG_LIMIT[0]));
	localparam longint K_D3 = rnd_gain(longint'(SEG_GAIN[2]), longint'(SEG_LIMIT[2]))
		- rnd_gain(longint'(SEG_GAIN[3]), longint'(SEG_LIMIT[2]));
	localparam longint K_D4 = rnd_gain(longint'(SEG_GAIN[3]), longint'(SEG_LIMIT[3]))
		- rnd_gain(longint'(SEG_GAIN[4]), longint'(SEG_LIMIT[3]));
	localparam longint K_D5 = rnd_gain(longint'(SEG_GAIN[4]), longint'(SEG_LIMIT[4]))
		- rnd_gain(longint'(SEG_GAIN[5]), longint'(SEG_LIMIT[4]));

	// segment offsets for a threshold; only segment two onwards moves with it,
	// and every offset stays well inside 26 bits so no saturation is reached
	function automatic offs_arr_t calc_offs(input logic [THR_W-1:0] thr);
		logic [PROD_W-1:0]         prod;
		logic [PROD_W:0]           rsum;
		logic signed [OFFS_XW-1:0] adj1;
		logic signed [OFFS_XW-1:0] off2;
		logic signed [OFFS_XW-1:0] off4;
		logic signed [OFFS_XW-1:0] off5;
		offs_arr_t                 offs;
		prod = PROD_W'(SEG_GAIN[NOISE_SEG+1]) * PROD_W'(thr);
		rsum = {1'b0, prod} + ROUND_HALF;
		// unity gain on the noise segment, so its product is the threshold itself
		adj1 = OFFS_XW'(K_OFF1) + OFFS_XW'(thr);
		off2 = adj1 - OFFS_XW'(rsum[PROD_W-1:FRAC_W]);
		off4 = off2 + OFFS_XW'(K_D3 + K_D4);
		off5 = off4 + OFFS_XW'(K_D5);
		offs[0] = '0;
		offs[1] = OFFS_W'(K_OFF1);
		offs[2] = OFFS_W'(off2);
		offs[3] = OFFS_W'(off2 + OFFS_XW'(K_D3));
		offs[4] = OFFS_W'(off4);
		offs[5] = OFFS_W'(off5);
		return offs;
	endfunction

	localparam offs_arr_t OFFS_RESET = calc_offs(THR_RESET);

endpackage

// File: hdl/pal_cell.sv
// one pass of the levelling curve: segment search and gain product, then
// offset, sign and saturation (or pass-through when not active), two register stages with stall handshake
// depends on pal_pkg
module pal_cell import pal_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     active,
	input  pal_cfg_t cfg,
	input  logic     up_valid,
	output logic     up_stall,
	input  pal_smp_t up_item,
	output logic     dn_valid,
	input  logic     dn_stall,
	output pal_smp_t dn_item
);

	logic valid_s1, valid_s2;
	logic stall_s1, stall_s2;

	logic [PROD_W-1:0] prod_s1;
	logic [SEG_W-1:0]  seg_s1;
	logic              hit_s1;
	logic              neg_s1;
	pal_smp_t          item_s1;
	pal_smp_t          item_s2;

	logic              neg;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  lim;
	logic [SEG_W-1:0]  seg;
	logic              hit;
	logic [PROD_W-1:0] prod;

	logic [PROD_W:0]          rsum;
	logic signed [VAL_W-1:0]  val;
	logic signed [VAL_W-1:0]  sval;
	logic [SMP_W-1:0]         lev;
	pal_smp_t                 next_s2;

	// stall ripples back only through full stages
	assign stall_s2 = valid_s2 && dn_stall;
	assign stall_s1 = valid_s1 && stall_s2;
	assign up_stall = stall_s1;
	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

	// magnitude and first segment whose breakpoint covers it
	always_comb begin
		neg = up_item.sample[SMP_W-1];
		mag = neg ? MAG_W'(-up_item.sample) : MAG_W'(up_item.sample);
		seg = '0;
		hit = 1'b0;
		lim = '0;
		for (int f = SEGMENTS - 1; f >= 0; f--) begin
			lim = (f == NOISE_SEG) ? MAG_W'(cfg.threshold) : SEG_LIMIT[f];
			if (mag <= lim) begin
				seg = SEG_W'(f);
				hit = 1'b1;
			end
		end
		prod = PROD_W'(SEG_GAIN[seg]) * PROD_W'(mag);
	end

	// round, add offset, restore sign and saturate
	always_comb begin
		rsum = {1'b0, prod_s1} + ROUND_HALF;
		if (hit_s1) begin
			val = VAL_W'(rsum[PROD_W-1:FRAC_W]) + VAL_W'($signed(cfg.offsets[seg_s1]));
		end else begin
			val = VAL_W'(CLIP_099);
		end
		sval = neg_s1 ? -val : val;
		if (sval > SAT_HI) begin
			lev = SMP_W'(SAT_HI);
		end else if (sval < SAT_LO) begin
			lev = SMP_W'(SAT_LO);
		end else begin
			lev = sval[SMP_W-1:0];
		end
		next_s2.sample = active ? lev : item_s1.sample;
		next_s2.last   = item_s1.last;
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!stall_s1) begin
				valid_s1 <= up_valid;
			end
			if (!stall_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (up_valid && !stall_s1) begin
			prod_s1 <= prod;
			seg_s1  <= seg;
			hit_s1  <= hit;
			neg_s1  <= neg;
			item_s1 <= up_item;
		end
		if (valid_s1 && !stall_s2) begin
			item_s2 <= next_s2;
		end
	end

endmodule

// File: hdl/piecewise_amplitude_leveller_unit.sv
// top level of the piecewise amplitude leveller: config registers,
// segment offset register and the chain of pass cells
// depends on pal_pkg and pal_cell
//
// each sample goes through the two register stages of all MAX_PASSES cells
// throughput: one item per cycle unless result_stall holds the chain;
// unused passes still flow through their cell
// reset: threshold 839, two passes, offsets preloaded, chain empty
module piecewise_amplitude_leveller_unit import pal_pkg::*; #(
	parameter int MAX_PASSES = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  pal_in_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output pal_out_t          result
);

	logic [THR_W-1:0]  thr_q;
	logic [PASS_W-1:0] passes_q;
	offs_arr_t         offs_q;
	logic              wr;
	pal_reg_t          reg_sel;
	logic [CNT_W-1:0]  passes_eff;
	logic [MAX_PASSES-1:0] act;
	pal_cfg_t          cfg;

	logic     chain_valid [MAX_PASSES+1];
	logic     chain_stall [MAX_PASSES+1];
	pal_smp_t chain_item  [MAX_PASSES+1];

	// config port
	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_sel = pal_reg_t'(paddr[2]);

	always_comb begin
		case (reg_sel)
			REG_NOISE_THRESHOLD: prdata = DATA_W'(thr_q);
			REG_NUM_PASSES:      prdata = DATA_W'(passes_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			passes_q <= PASSES_RESET;
		end else if (wr) begin
			case (reg_sel)
				REG_NOISE_THRESHOLD: thr_q    <= pwdata[THR_W-1:0];
				REG_NUM_PASSES:      passes_q <= pwdata[PASS_W-1:0];
				default: ;
			endcase
		end
	end

	// offsets follow the threshold in the cycle after it changes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q <= OFFS_RESET;
		end else begin
			offs_q <= calc_offs(thr_q);
		end
	end

	// pass count clipped to the chain length, one enable per cell
	always_comb begin
		if (CNT_W'(passes_q) > CNT_W'(MAX_PASSES)) begin
			passes_eff = CNT_W'(MAX_PASSES);
		end else begin
			passes_eff = CNT_W'(passes_q);
		end
		for (int k = 0; k < MAX_PASSES; k++) begin
			act[k] = CNT_W'(k) < passes_eff;
		end
	end

	assign cfg.threshold = thr_q;
	assign cfg.offsets   = offs_q;

	// chain ends
	assign chain_valid[0]          = sample_valid;
	assign chain_item[0].sample    = sample.sample_in;
	assign chain_item[0].last      = sample.last_in;
	assign sample_stall            = chain_stall[0];
	assign result_valid            = chain_valid[MAX_PASSES];
	assign chain_stall[MAX_PASSES] = result_stall;
	assign result.sample_out       = chain_item[MAX_PASSES].sample;
	assign result.last_out         = chain_item[MAX_PASSES].last;

	// one cell per pass
	for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
		pal_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.active   (act[k]),
			.cfg      (cfg),
			.up_valid (chain_valid[k]),
			.up_stall (chain_stall[k]),
			.up_item  (chain_item[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_stall (chain_stall[k+1]),
			.dn_item  (chain_item[k+1])
		);
	end

`ifndef NO_ASSERTIONS
	// offsets always belong to the threshold of the previous cycle
	a_offs_track: assert property (@(posedge clk) disable iff (!arst_n)
		offs_q == calc_offs($past(thr_q)))
		else $error("segment offsets out of step with threshold");

	// the head of the chain only stalls when a result is being held
	a_stall_origin: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");
`endif

endmodule

// File: tb/piecewise_amplitude_leveller_unit_test.sv
// testbench for piecewise_amplitude_leveller_unit: drives samples through the
// curve chain, predicts each levelled sample and checks results in order
// depends on pal_pkg and the leveller rtl
module piecewise_amplitude_leveller_unit_test;
	import pal_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PASS_CAP   = 5;
	localparam int CHAIN_LAT  = 2 * PASS_CAP;
	localparam int LONG_HOLD  = 80;
	localparam int PHASES     = 9;
	localparam int PHASE_LEN  = 150;
	localparam int N_DIRECTED = 18;
	localparam longint CLIP_MAG = 8304722;
	localparam longint OUT_MAX  = 8388607;
	localparam longint OUT_MIN  = -8388608;
	localparam longint OFF_MAX  = 33554431;
	localparam longint OFF_MIN  = -33554432;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              sample_valid = 1'b0;
	logic              sample_stall;
	pal_in_t           sample = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	pal_out_t          result;

	// predictor copy of the configuration and the offsets it implies
	logic [THR_W-1:0]  thr_cfg;
	logic [PASS_W-1:0] passes_cfg;
	longint            seg_offs [6];

	pal_in_t  samples_waiting [$];
	pal_out_t levelled_due [$];
	pal_out_t want;
	int       faults = 0;
	int       send_gap;
	int       rx_gap;
	int       hold_reqs = 0;
	int       hold_seen;
	bit       calm = 1'b0;

	piecewise_amplitude_leveller_unit #(.MAX_PASSES(PASS_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// curve tables, segment 0 first
	function automatic longint gain_of(input int f);
		case (f)
			0, 5:    return 13107;
			1, 4:    return 16384;
			default: return 19661;
		endcase
	endfunction

	function automatic longint knee(input int f);
		case (f)
			0:       return 839;
			1:       return longint'(thr_cfg);
			2:       return 838861;
			3:       return 2516582;
			4:       return 4194304;
			default: return 8388608;
		endcase
	endfunction

	function automatic longint gain_round(input longint g, input longint x);
		return (g * x + 8192) >>> 14;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// offsets that keep the curve continuous for the current threshold
	function automatic void refresh_offsets();
		longint carry;
		seg_offs[0] = 0;
		carry = gain_round(gain_of(0), knee(0));
		for (int f = 1; f < 6; f++) begin
			seg_offs[f] = clamp(carry - gain_round(gain_of(f), knee(f - 1)), OFF_MIN, OFF_MAX);
			carry = gain_round(gain_of(f), knee(f)) + seg_offs[f];
		end
	endfunction

	// one trip through the curve, first matching segment wins
	function automatic longint level_pass(input longint x);
		longint mag;
		longint v;
		bit     neg;
		bit     hit;
		neg = x < 0;
		mag = neg ? -x : x;
		v = CLIP_MAG;
		hit = 1'b0;
		for (int f = 0; f < 6; f++) begin
			if (!hit && mag <= knee(f)) begin
				v = gain_round(gain_of(f), mag) + seg_offs[f];
				hit = 1'b1;
			end
		end
		return clamp(neg ? -v : v, OUT_MIN, OUT_MAX);
	endfunction

	function automatic pal_out_t levelled_of(input pal_in_t it);
		longint   x;
		int       passes;
		pal_out_t r;
		x = longint'($signed(it.sample_in));
		passes = (passes_cfg > PASS_CAP) ? PASS_CAP : int'(passes_cfg);
		for (int p = 0; p < passes; p++)
			x = level_pass(x);
		r.sample_out = x[SMP_W-1:0];
		r.last_out = it.last_in;
		return r;
	endfunction

	// random sample: plain random, near a breakpoint, tiny, extreme or any in-range magnitude
	function automatic pal_in_t pick_sample();
		pal_in_t it;
		longint  m;
		m = 0;
		it.sample_in = SMP_W'($urandom);
		case ($urandom_range(0, 5))
			2: m = clamp(knee($urandom_range(0, 5)) + longint'($urandom_range(0, 6)) - 3,
				0, 8388608);
			3: m = longint'($urandom_range(0, 3000));
			4: m = $urandom_range(0, 1) ? 8388608 : longint'($urandom_range(0, 1));
			5: m = longint'($urandom_range(0, 8388607));
			default: m = -1;
		endcase
		if (m >= 0)
			it.sample_in = $urandom_range(0, 1) ? SMP_W'(-m) : SMP_W'(m);
		it.last_in = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// config write over the apb port, setup then access
	task automatic write_reg(input pal_reg_t idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_NOISE_THRESHOLD) begin
			thr_cfg = value[THR_W-1:0];
			refresh_offsets();
		end else
			passes_cfg = value[PASS_W-1:0];
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (samples_waiting.size() != 0 || sample_valid || levelled_due.size() != 0);
	endtask

	// sample driver, keeps a stalled item steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			send_gap <= 0;
		end else begin
			if (sample_valid && !sample_stall)
				levelled_due.push_back(levelled_of(sample));
			if (!sample_valid || !sample_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 6);
					sample_valid <= 1'b0;
				end else if (samples_waiting.size() > 0) begin
					sample <= samples_waiting.pop_front();
					sample_valid <= 1'b1;
				end else
					sample_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_gap <= 0;
			hold_seen <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (levelled_due.size() == 0) begin
					$display("%0t: unexpected item, actual %h", $time, result);
					faults++;
				end else begin
					want = levelled_due.pop_front();
					if (result.sample_out !== want.sample_out) begin
						$display("%0t: sample_out expected %0d actual %0d", $time,
							$signed(want.sample_out), $signed(result.sample_out));
						faults++;
					end
					if (result.last_out !== want.last_out) begin
						$display("%0t: last_out expected %b actual %b", $time,
							want.last_out, result.last_out);
						faults++;
					end
				end
			end
			if (hold_seen != hold_reqs) begin
				hold_seen <= hold_reqs;
				rx_gap <= LONG_HOLD - 1;
				result_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rx_gap <= $urandom_range(0, 6);
				result_stall <= 1'b1;
			end else
				result_stall <= 1'b0;
		end
	end

	// stimulus: directed items at reset settings, then one random phase per setting
	initial begin
		int      directed [N_DIRECTED];
		int      p_thr [PHASES];
		int      p_pass [PHASES];
		pal_in_t it;
		logic [THR_W-1:0] thr;
		logic [PASS_W-1:0] np;
		directed = '{0, 1, -1, 8388607, -8388608, 839, -839, 840, 838861, -838862,
			2516582, 2516583, -4194304, 4194305, 8388606, -8388607, 100, -2};
		// a negative entry means pick at random
		p_thr = '{0, 8388607, 839, 838861, -1, 1, -1, 838862, -1};
		p_pass = '{0, 7, 1, 5, 3, 6, 4, 2, -1};
		thr_cfg = THR_RESET;
		passes_cfg = PASSES_RESET;
		refresh_offsets();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < N_DIRECTED; i++) begin
			it.sample_in = SMP_W'(directed[i]);
			it.last_in = i[0];
			samples_waiting.push_back(it);
		end
		for (int ph = 0; ph < PHASES; ph++) begin
			// sender waits until the chain is empty before touching config
			wait_drained();
			thr = (p_thr[ph] < 0) ? THR_W'($urandom) : THR_W'(p_thr[ph]);
			np = (p_pass[ph] < 0) ? PASS_W'($urandom) : PASS_W'(p_pass[ph]);
			write_reg(REG_NOISE_THRESHOLD, DATA_W'(thr));
			write_reg(REG_NUM_PASSES, DATA_W'(np));
			@(negedge clk);
			if (ph == 3)
				hold_reqs++;
			if (ph == PHASES - 1)
				calm = 1'b1;
			for (int i = 0; i < PHASE_LEN; i++)
				samples_waiting.push_back(pick_sample());
		end
		wait_drained();
		repeat (CHAIN_LAT + 4) @(negedge clk);
		if (faults == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/piecewise_amplitude_leveller_unit.sv
tb/piecewise_amplitude_leveller_unit_test.sv
